>>> rtl/core/mxt_pkg.sv
// shared types and codes for the maximum-xor binary trie
package mxt_pkg;

	localparam int KEY_BITS = 31;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_QUERY  = 2'd1,
		OP_EMPTY  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_WALK  = 2'd1,
		BK_ALLOC = 2'd2
	} bk_state_t;

	typedef struct packed {
		logic                func;
		logic [KEY_BITS-1:0] key;
	} in_word_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] best_xor;
		status_t             status;
	} out_word_t;

	// classified word handed from the front to the back
	typedef struct packed {
		logic                valid;
		op_t                 op;
		logic [KEY_BITS-1:0] key;
	} job_t;

endpackage

>>> rtl/core/max_xor_binary_trie.sv
// top level of the maximum-xor binary trie
//
//  channel   signals               transfer
//  command   start, busy, cmd      start && !busy at a rising edge
//  result    done, result          done high for one cycle, always taken
//
// a query walks from the root toward the child opposite each key bit, with
// at most one node-store read per key bit; an empty-trie query skips the walk
// an insert walks its existing prefix one level a cycle, links the first new
// node into its parent, then allocates one node a cycle for the missing levels
// the front queue holds two words; busy is high while it is full
// reset leaves the root with no children and node 1 as the next free node
// the result side cannot stall, so the back end never waits on it
module max_xor_binary_trie
	import mxt_pkg::*;
#(
	parameter int NODE_COUNT = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_word_t  cmd,
	output logic      done,
	output out_word_t result
);

	job_t job;
	logic pop;

	// accept and classify
	mxt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.job    (job),
		.pop    (pop)
	);

	// trie walks and allocation
	mxt_back #(
		.NODE_COUNT (NODE_COUNT)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

>>> rtl/core/mxt_front.sv
// front end: accepts command words, classifies them and queues them
module mxt_front
	import mxt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  in_word_t cmd,
	output job_t     job,
	input  logic     pop
);

	localparam int QD = 2;

	op_t                 op_q  [QD];
	logic [KEY_BITS-1:0] key_q [QD];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          count_q;
	logic                seen_insert_q;
	logic                push;
	logic                pop_ok;
	op_t                 op_in;

	assign busy   = (count_q == 2'(QD));
	assign push   = start && !busy;
	assign pop_ok = pop && (count_q != 2'd0);

	// a query before any insert can only see an empty trie
	always_comb begin
		if (cmd.func == FUNC_INSERT) begin
			op_in = OP_INSERT;
		end else if (seen_insert_q) begin
			op_in = OP_QUERY;
		end else begin
			op_in = OP_EMPTY;
		end
	end

	// queue head
	assign job.valid = (count_q != 2'd0);
	assign job.op    = op_q[rd_ptr_q];
	assign job.key   = key_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]  <= op_in;
			key_q[wr_ptr_q] <= cmd.key;
		end
	end

	// queue pointers and insert flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q      <= 1'b0;
			rd_ptr_q      <= 1'b0;
			count_q       <= 2'd0;
			seen_insert_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
				if (cmd.func == FUNC_INSERT) begin
					seen_insert_q <= 1'b1;
				end
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop_ok})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/mxt_back.sv
// back end: walks the node store for queries and inserts, allocates nodes
module mxt_back
	import mxt_pkg::*;
#(
	parameter int NODE_COUNT = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      job,
	output logic      pop,
	output logic      done,
	output out_word_t result
);

	localparam int IDX_W = $clog2(NODE_COUNT);
	localparam int NF_W  = $clog2(NODE_COUNT + 1);
	localparam int LVL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

	typedef logic [1:0][IDX_W-1:0] row_t;

	// node store, root kept in flops
	row_t mem [NODE_COUNT];
	row_t rdata_q;
	row_t root_q, root_d;

	bk_state_t           state_q, state_d;
	op_t                 op_q, op_d;
	logic [KEY_BITS-1:0] key_q, key_d;
	logic [KEY_BITS-1:0] ans_q, ans_d;
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic [LVL_W-1:0]    lvl_q, lvl_d;
	logic [NF_W-1:0]     free_q, free_d;
	logic                done_q, done_d;
	out_word_t           res_q, res_d;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	row_t             wr_data;

	row_t             cur;
	row_t             new_row;
	logic             kb;
	logic [IDX_W-1:0] ch;
	logic [IDX_W-1:0] ot;
	logic [IDX_W-1:0] nxt;
	logic             go;
	logic             fin;
	logic [NF_W:0]    need_end;
	logic [LVL_W-1:0] lvl_m1;
	logic [IDX_W-1:0] alloc_idx;

	assign cur       = (idx_q == '0) ? root_q : rdata_q;
	assign kb        = key_q[lvl_q];
	assign ch        = cur[kb];
	assign ot        = cur[~kb];
	assign lvl_m1    = lvl_q - LVL_W'(1);
	assign alloc_idx = free_q[IDX_W-1:0];
	assign need_end  = {1'b0, free_q} + (NF_W+1)'(lvl_q) + (NF_W+1)'(1);

	// next state and datapath control
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		key_d   = key_q;
		ans_d   = ans_q;
		idx_d   = idx_q;
		lvl_d   = lvl_q;
		free_d  = free_q;
		root_d  = root_q;
		done_d  = 1'b0;
		res_d   = res_q;
		pop     = 1'b0;
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		new_row = cur;
		nxt     = '0;
		go      = 1'b0;
		fin     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (job.valid) begin
					pop   = 1'b1;
					op_d  = job.op;
					key_d = job.key;
					ans_d = '0;
					idx_d = '0;
					lvl_d = LVL_W'(KEY_BITS - 1);
					if (job.op == OP_EMPTY) begin
						done_d = 1'b1;
						res_d  = '{best_xor: '0, status: ST_EMPTY};
					end else begin
						state_d = BK_WALK;
					end
				end
			end
			BK_WALK: begin
				if (op_q == OP_QUERY) begin
					// prefer the child opposite to the key bit
					if (ot != '0) begin
						ans_d[lvl_q] = 1'b1;
						nxt = ot;
						go  = 1'b1;
					end else if (ch != '0) begin
						nxt = ch;
						go  = 1'b1;
					end else begin
						fin = 1'b1;
					end
					if (go && lvl_q == '0) begin
						fin = 1'b1;
					end
					if (fin) begin
						done_d  = 1'b1;
						res_d   = '{best_xor: ans_d, status: ST_OK};
						state_d = BK_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = nxt;
						idx_d   = nxt;
						lvl_d   = lvl_m1;
					end
				end else if (ch != '0) begin
					// existing path, keep walking
					if (lvl_q == '0) begin
						done_d  = 1'b1;
						res_d   = '{best_xor: '0, status: ST_OK};
						state_d = BK_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = ch;
						idx_d   = ch;
						lvl_d   = lvl_m1;
					end
				end else if (need_end > (NF_W+1)'(NODE_COUNT)) begin
					// not enough free nodes for the rest of the path
					done_d  = 1'b1;
					res_d   = '{best_xor: '0, status: ST_FULL};
					state_d = BK_IDLE;
				end else begin
					// link the first new node into its parent
					new_row[kb] = alloc_idx;
					if (idx_q == '0) begin
						root_d = new_row;
					end else begin
						wr_en   = 1'b1;
						wr_addr = idx_q;
						wr_data = new_row;
					end
					state_d = BK_ALLOC;
				end
			end
			BK_ALLOC: begin
				// one new node per cycle, each pointing at the next
				wr_en   = 1'b1;
				wr_addr = alloc_idx;
				if (lvl_q != '0) begin
					wr_data[key_q[lvl_m1]] = alloc_idx + IDX_W'(1);
				end
				free_d = free_q + NF_W'(1);
				if (lvl_q == '0) begin
					done_d  = 1'b1;
					res_d   = '{best_xor: '0, status: ST_OK};
					state_d = BK_IDLE;
				end else begin
					lvl_d = lvl_m1;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// node store ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
			lvl_q   <= '0;
			free_q  <= NF_W'(1);
			root_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			lvl_q   <= lvl_d;
			free_q  <= free_d;
			root_q  <= root_d;
			done_q  <= done_d;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		op_q  <= op_d;
		key_q <= key_d;
		ans_q <= ans_d;
		res_q <= res_d;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> rtl/core/mxt_checker.sv
// port-level checks for the maximum-xor binary trie, bound to the top level
module mxt_checker
	import mxt_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_word_t result
);

	// status is one of the three defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_OK || result.status == ST_EMPTY ||
			result.status == ST_FULL))
	else $error("undefined status code on result");

	// an empty-trie query answers zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_EMPTY) |-> (result.best_xor == '0))
	else $error("empty query with nonzero answer");

	// a rejected insert answers zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |-> (result.best_xor == '0))
	else $error("rejected insert with nonzero answer");

	// busy only after a word has been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
	else $error("busy rose without an accepted word");

endmodule

bind max_xor_binary_trie mxt_checker u_mxt_checker (.*);

>>> tb/max_xor_binary_trie_tb.sv
// self-checking testbench for the maximum-xor binary trie: predictor, driver, monitor
`timescale 1ns / 1ps

module max_xor_binary_trie_tb;
	import mxt_pkg::*;

	localparam int NODE_COUNT = 4096;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start = 1'b0;
	logic      busy;
	in_word_t  cmd = '0;
	logic      done;
	out_word_t result;

	// words waiting to be sent, and results owed by the block in order
	in_word_t  pending_words [$];
	out_word_t expected_words [$];
	logic [KEY_BITS-1:0] stored_keys [$];

	int unsigned idle_pct = 0;
	int unsigned fail_count = 0;

	// shadow copy of the node store
	int unsigned trie_links [NODE_COUNT][2];
	int unsigned next_free = 1;
	bit          trie_loaded = 1'b0;

	max_xor_binary_trie #(
		.NODE_COUNT(NODE_COUNT)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done),
		.result(result)
	);

	always #1 clk = ~clk;

	// applies one accepted word to the shadow trie and returns the result it owes
	function automatic out_word_t trie_apply(in_word_t w);
		out_word_t   res;
		int unsigned node;
		int unsigned need;
		bit          missing;
		bit          b;
		res.best_xor = '0;
		res.status   = ST_OK;
		if (w.func == FUNC_INSERT) begin
			// count the nodes the path still lacks
			node    = 0;
			need    = 0;
			missing = 1'b0;
			for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
				b = w.key[lvl];
				if (missing)
					need++;
				else if (trie_links[node][b] == 0) begin
					missing = 1'b1;
					need++;
				end else
					node = trie_links[node][b];
			end
			if (next_free + need > NODE_COUNT)
				res.status = ST_FULL;
			else begin
				node = 0;
				for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
					b = w.key[lvl];
					if (trie_links[node][b] == 0) begin
						trie_links[node][b] = next_free;
						next_free++;
					end
					node = trie_links[node][b];
				end
				trie_loaded = 1'b1;
			end
		end else if (!trie_loaded)
			res.status = ST_EMPTY;
		else begin
			// greedy walk toward the opposite bit
			node = 0;
			for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
				b = w.key[lvl];
				if (trie_links[node][!b] != 0) begin
					res.best_xor[lvl] = 1'b1;
					node = trie_links[node][!b];
				end else if (trie_links[node][b] != 0)
					node = trie_links[node][b];
				else
					break;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		fail_count++;
		if (fail_count <= 40)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// driver: one word offered at a time, held while busy
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd   <= '0;
		end else begin
			if (start && !busy)
				expected_words = {expected_words, trie_apply(cmd)};
			if (start && busy) begin
				// keep the word on the port until taken
			end else if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				cmd   <= pending_words.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every result is checked against the oldest expectation
	always @(posedge clk) begin : result_check
		out_word_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_words.size() == 0)
				report_mismatch($sformatf("unexpected result best_xor %h status %0d",
					result.best_xor, result.status));
			else begin
				want = expected_words.pop_front();
				if (result.best_xor !== want.best_xor)
					report_mismatch($sformatf("best_xor %h, want %h",
						result.best_xor, want.best_xor));
				if (result.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						result.status, want.status));
			end
		end
	end

	task automatic queue_word(logic f, logic [KEY_BITS-1:0] k);
		in_word_t w;
		w.func = f;
		w.key  = k;
		pending_words = {pending_words, w};
		if (f == FUNC_INSERT)
			stored_keys = {stored_keys, k};
	endtask

	// either a fresh key or a stored key with a random run of low bits changed
	function automatic logic [KEY_BITS-1:0] pick_key(int unsigned fresh_pct);
		int unsigned     span;
		longint unsigned mask;
		if (stored_keys.size() == 0 || $urandom_range(99) < fresh_pct)
			return KEY_BITS'($urandom);
		span = $urandom_range(KEY_BITS);
		mask = (64'd1 << span) - 1;
		return stored_keys[$urandom_range(stored_keys.size() - 1)] ^
			(KEY_BITS'($urandom) & KEY_BITS'(mask));
	endfunction

	task automatic queue_random(int unsigned count, int unsigned fresh_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 55)
				queue_word(FUNC_INSERT, pick_key(fresh_pct));
			else
				queue_word(FUNC_QUERY, pick_key(50));
		end
	endtask

	// wait until every queued word has gone in and every result has come back
	task automatic wait_drained();
		@(negedge clk);
		while (pending_words.size() != 0 || start || expected_words.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty queries, extreme keys, duplicates, short shared paths
		queue_word(FUNC_QUERY,  31'h0000_0000);
		queue_word(FUNC_QUERY,  31'h7FFF_FFFF);
		queue_word(FUNC_INSERT, 31'h0000_0000);
		queue_word(FUNC_QUERY,  31'h0000_0000);
		queue_word(FUNC_QUERY,  31'h7FFF_FFFF);
		queue_word(FUNC_INSERT, 31'h0000_0000);
		queue_word(FUNC_INSERT, 31'h7FFF_FFFF);
		queue_word(FUNC_QUERY,  31'h0000_0000);
		queue_word(FUNC_QUERY,  31'h2AAA_AAAA);
		queue_word(FUNC_INSERT, 31'h5555_5555);
		queue_word(FUNC_INSERT, 31'h2AAA_AAAA);
		queue_word(FUNC_QUERY,  31'h4000_0000);
		queue_word(FUNC_INSERT, 31'h0000_0001);
		queue_word(FUNC_QUERY,  31'h0000_0001);
		queue_word(FUNC_INSERT, 31'h4000_0000);
		queue_word(FUNC_QUERY,  31'h3FFF_FFFF);
		queue_word(FUNC_INSERT, 31'h7FFF_FFFE);
		queue_word(FUNC_QUERY,  31'h7FFF_FFFF);
		queue_word(FUNC_INSERT, 31'h7FFF_FFFF);
		queue_word(FUNC_QUERY,  31'h1234_5678);
		wait_drained();

		// sender idles often, then more often, then never
		idle_pct = 30;
		queue_random(210, 20);
		wait_drained();
		idle_pct = 48;
		queue_random(210, 20);
		wait_drained();
		idle_pct = 0;
		queue_random(210, 50);
		wait_drained();

		repeat (64) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
